@@ design/slsd_pkg.sv @@
// ----------------------------------------------------------------------------
// slsd_pkg
// Shared types and constants for the sync/length/sum-checksum deframer.
// ----------------------------------------------------------------------------
package slsd_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_PREAMBLE   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BUS_ID     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MESSAGE_ID = 2'd2;

   // register reset values
   localparam logic [ByteWidth-1:0] PreambleReset  = 8'd250;
   localparam logic [ByteWidth-1:0] BusIdReset     = 8'd255;
   localparam logic [ByteWidth-1:0] MessageIdReset = 8'd50;

   // one result item
   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic [ByteWidth-1:0] byte_index;
      logic                 frame_end;
      logic                 checksum_good;
      logic [ByteWidth-1:0] frame_length;
   } result_type;

   // header match values handed to the parser
   typedef struct packed {
      logic [ByteWidth-1:0] preamble;
      logic [ByteWidth-1:0] bus_id;
      logic [ByteWidth-1:0] message_id;
   } header_cfg_type;

endpackage

@@ design/sync_length_sum_checksum_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_length_sum_checksum_deframer
// Byte-stream frame parser with header match and additive checksum.
// ----------------------------------------------------------------------------
// One received byte per item, one item per clock sustained. The block hunts
// for the preamble byte, then needs the bus-id and message-id bytes (a
// mismatch drops back to hunting; that byte is not re-checked as a preamble),
// then a length byte, that many payload bytes and one checksum byte. Every
// byte after the preamble is summed mod 256; the frame is good when the sum
// ends at zero. Each payload byte yields a result with its index; the checksum
// byte yields an end result (frame_end = 1, byte_index = frame_length) with
// checksum_good. Header bytes yield nothing. The parser state and 8-bit add
// feed a single result register, so rsp_valid rises in the cycle after the
// accept. req_stall rises only while that register holds a result refused by
// rsp_stall, so with a free-running consumer no input is ever stalled. The
// three match bytes are to be written through the csr_ port while the block
// is idle, which the block does not enforce; an unused csr_index is ignored.
// ----------------------------------------------------------------------------
module sync_length_sum_checksum_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write,
   input  logic [slsd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [slsd_pkg::ByteWidth-1:0]       csr_wdata,
   // byte input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [slsd_pkg::ByteWidth-1:0]       req_rx_byte,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [slsd_pkg::ByteWidth-1:0]       rsp_data_byte,
   output logic [slsd_pkg::ByteWidth-1:0]       rsp_byte_index,
   output logic                                 rsp_frame_end,
   output logic                                 rsp_checksum_good,
   output logic [slsd_pkg::ByteWidth-1:0]       rsp_frame_length
);

   slsd_pkg::header_cfg_type cfg_ff;
   logic                     accept;
   logic                     emit;
   slsd_pkg::result_type     result;
   logic                     rsp_valid_ff, rsp_valid_in;
   slsd_pkg::result_type     rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble   <= slsd_pkg::PreambleReset;
         cfg_ff.bus_id     <= slsd_pkg::BusIdReset;
         cfg_ff.message_id <= slsd_pkg::MessageIdReset;
      end else if (csr_write) begin
         case (csr_index)
            slsd_pkg::CSR_PREAMBLE:   cfg_ff.preamble   <= csr_wdata;
            slsd_pkg::CSR_BUS_ID:     cfg_ff.bus_id     <= csr_wdata;
            slsd_pkg::CSR_MESSAGE_ID: cfg_ff.message_id <= csr_wdata;
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // take a byte whenever the result register is free or draining this cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   slsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (result)
   );

   // result register
   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_ff.data_byte;
   assign rsp_byte_index    = rsp_ff.byte_index;
   assign rsp_frame_end     = rsp_ff.frame_end;
   assign rsp_checksum_good = rsp_ff.checksum_good;
   assign rsp_frame_length  = rsp_ff.frame_length;

endmodule

@@ design/slsd_parser.sv @@
// ----------------------------------------------------------------------------
// slsd_parser
// Frame state machine: header match, length capture, payload count and
// running 8-bit sum. Produces the result for the current byte combinationally.
// ----------------------------------------------------------------------------
module slsd_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [slsd_pkg::ByteWidth-1:0]  rx_byte,
   input  slsd_pkg::header_cfg_type        cfg,
   output logic                            emit,
   output slsd_pkg::result_type            result
);

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_SYNC2   = 3'd2,
      PH_SYNC3   = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [slsd_pkg::ByteWidth-1:0] length_ff, length_in;
   logic [slsd_pkg::ByteWidth-1:0] count_ff, count_in;
   logic [slsd_pkg::ByteWidth-1:0] sum_ff, sum_in;
   logic [slsd_pkg::ByteWidth-1:0] sum_add;

   assign sum_add = sum_ff + rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      emit      = 1'b0;
      result.data_byte     = rx_byte;
      result.byte_index    = count_ff;
      result.frame_end     = 1'b0;
      result.checksum_good = 1'b0;
      result.frame_length  = length_ff;
      case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == cfg.bus_id) begin
               sum_in   = rx_byte;
               phase_in = PH_SYNC2;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_SYNC2: begin
            if (rx_byte == cfg.message_id) begin
               sum_in   = sum_add;
               phase_in = PH_SYNC3;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_SYNC3: begin
            length_in = rx_byte;
            count_in  = '0;
            sum_in    = sum_add;
            phase_in  = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            emit   = 1'b1;
            sum_in = sum_add;
            if (count_ff < length_ff) begin
               count_in = count_ff + 1'b1;
            end else begin
               // checksum byte closes the frame
               result.frame_end     = 1'b1;
               result.checksum_good = (sum_add == '0);
               phase_in  = PH_HUNT;
               length_in = '0;
               count_in  = '0;
               sum_in    = '0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == cfg.preamble) begin
               sum_in   = '0;
               phase_in = PH_SYNC1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

@@ design/slsd_checker.sv @@
// ----------------------------------------------------------------------------
// slsd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module slsd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [slsd_pkg::ByteWidth-1:0]  rsp_data_byte,
   input logic [slsd_pkg::ByteWidth-1:0]  rsp_byte_index,
   input logic                            rsp_frame_end,
   input logic                            rsp_checksum_good,
   input logic [slsd_pkg::ByteWidth-1:0]  rsp_frame_length
);

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input only stalls behind a refused result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a pending result");

   // payload results sit inside the payload and carry no good flag
   a_payload_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_end) |->
         ((rsp_byte_index < rsp_frame_length) && !rsp_checksum_good))
      else $error("payload result out of range");

   // end result index equals the frame length
   a_end_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_byte_index == rsp_frame_length))
      else $error("end result index mismatch");

   // a refused result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_data_byte) && $stable(rsp_byte_index)
          && $stable(rsp_frame_end) && $stable(rsp_checksum_good)))
      else $error("stalled result changed");

endmodule

bind sync_length_sum_checksum_deframer slsd_checker u_slsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_byte_index    (rsp_byte_index),
   .rsp_frame_end     (rsp_frame_end),
   .rsp_checksum_good (rsp_checksum_good),
   .rsp_frame_length  (rsp_frame_length)
);
